>>> hdl/ffba_pkg.sv
// shared types and constants for the first-fit block allocator
package ffba_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 64;
  localparam int unsigned MAX_RESULTS    = 64;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned ID_W           = 6;
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned QPTR_W         = $clog2(QDEPTH);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(64);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_IGNORED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    K_ZERO,
    K_BIG,
    K_ALLOC,
    K_FREE
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [CNT_W-1:0] want;
    logic [ID_W-1:0]  fid;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_word_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

>>> hdl/ffba_front.sv
// request intake: classifies each word and queues it for the back end
module ffba_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode_i,
  input  logic [ffba_pkg::CNT_W-1:0]    request_count_i,
  input  logic [ffba_pkg::ID_W-1:0]     free_id_i,
  input  ffba_pkg::back_ctl_t           back_ctl_i,
  output ffba_pkg::cmd_word_t           cmd_o
);
  import ffba_pkg::*;

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  cmd_t              cls;
  logic              push;
  logic              pop;

  always_comb begin
    cls.want = request_count_i;
    cls.fid  = free_id_i;
    if (opcode_i == OP_FREE) begin
      cls.kind = K_FREE;
    end else if (request_count_i == '0) begin
      cls.kind = K_ZERO;
    end else if (request_count_i > CNT_W'(MAX_RESULTS)) begin
      cls.kind = K_BIG;
    end else begin
      cls.kind = K_ALLOC;
    end
  end

  assign busy  = (cnt_q == (QPTR_W+1)'(QDEPTH)) || back_ctl_i.clearing;
  assign push  = start && !busy;
  assign pop   = back_ctl_i.pop && (cnt_q != '0);

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> hdl/ffba_back.sv
// execution back end: in-use bitmap memory, first-fit scan, free and recount
module ffba_back #(
  parameter int unsigned NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffba_pkg::cmd_word_t           cmd_i,
  output ffba_pkg::back_ctl_t           ctl_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffba_pkg::CNT_W-1:0]    cfg_data_i,
  output logic                          res_valid_o,
  output logic [ffba_pkg::ID_W-1:0]     block_id_o,
  output logic                          id_valid_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  output logic [ffba_pkg::CNT_W-1:0]    free_count_o
);
  import ffba_pkg::*;

  localparam int unsigned AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_RECOUNT
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    idx_q;
  logic             pend_q;
  logic [AW-1:0]    pend_id_q;
  logic [CNT_W-1:0] rem_q;
  logic [CNT_W-1:0] free_q;
  logic [CNT_W-1:0] limit_q;

  logic             res_valid_q;
  logic [ID_W-1:0]  res_id_q;
  logic             res_idv_q;
  status_e          res_status_q;
  logic             res_last_q;
  logic [CNT_W-1:0] res_free_q;

  logic             used_mem [NUM_BLOCKS];
  logic             rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic             mem_wd;
  logic [AW-1:0]    mem_ra;

  logic [LW-1:0]    lim_wide;
  logic [LW-1:0]    eff_lim;
  logic             take;

  assign lim_wide = LW'(limit_q);
  assign eff_lim  = (lim_wide > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : lim_wide;

  assign cfg_ready_o    = (state_q == S_IDLE);
  assign take           = (state_q == S_IDLE) && !cfg_valid_i && cmd_i.valid;
  assign ctl_o.pop      = take;
  assign ctl_o.clearing = (state_q == S_CLEAR);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pend_id_q;
    mem_wd = 1'b0;
    mem_ra = idx_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_q;
      end
      S_IDLE: begin
        mem_ra = AW'(cmd_i.cmd.fid);
      end
      S_SCAN: begin
        if (pend_q && !rd_q) begin
          mem_we = 1'b1;
          mem_wd = 1'b1;
        end
      end
      S_FREE: begin
        mem_we = rd_q;
      end
      S_RECOUNT: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      used_mem[mem_wa] <= mem_wd;
    end
    rd_q <= used_mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      pend_id_q    <= '0;
      rem_q        <= '0;
      free_q       <= '0;
      limit_q      <= LIMIT_RESET;
      res_valid_q  <= 1'b0;
      res_id_q     <= '0;
      res_idv_q    <= 1'b0;
      res_status_q <= ST_OK;
      res_last_q   <= 1'b0;
      res_free_q   <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + AW'(1);
          if (idx_q == AW'(NUM_BLOCKS - 1)) begin
            idx_q   <= '0;
            free_q  <= CNT_W'(eff_lim);
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cfg_valid_i) begin
            limit_q <= cfg_data_i;
            free_q  <= '0;
            idx_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= S_RECOUNT;
          end else if (cmd_i.valid) begin
            res_id_q   <= '0;
            res_idv_q  <= 1'b0;
            res_last_q <= 1'b1;
            res_free_q <= free_q;
            case (cmd_i.cmd.kind)
              K_ZERO: begin
                res_valid_q  <= 1'b1;
                res_status_q <= ST_OK;
              end
              K_BIG: begin
                res_valid_q  <= 1'b1;
                res_status_q <= ST_NO_SPACE;
              end
              K_ALLOC: begin
                if (cmd_i.cmd.want > free_q) begin
                  res_valid_q  <= 1'b1;
                  res_status_q <= ST_NO_SPACE;
                end else begin
                  rem_q   <= cmd_i.cmd.want;
                  idx_q   <= '0;
                  pend_q  <= 1'b0;
                  state_q <= S_SCAN;
                end
              end
              K_FREE: begin
                if (LW'(cmd_i.cmd.fid) >= eff_lim) begin
                  res_valid_q  <= 1'b1;
                  res_status_q <= ST_IGNORED;
                end else begin
                  pend_id_q <= AW'(cmd_i.cmd.fid);
                  state_q   <= S_FREE;
                end
              end
              default: begin
                res_valid_q <= 1'b0;
              end
            endcase
          end
        end
        S_SCAN: begin
          idx_q     <= idx_q + AW'(1);
          pend_q    <= 1'b1;
          pend_id_q <= idx_q;
          if (pend_q && !rd_q) begin
            res_valid_q  <= 1'b1;
            res_id_q     <= ID_W'(pend_id_q);
            res_idv_q    <= 1'b1;
            res_status_q <= ST_OK;
            res_last_q   <= (rem_q == CNT_W'(1));
            res_free_q   <= free_q - CNT_W'(1);
            free_q       <= free_q - CNT_W'(1);
            rem_q        <= rem_q - CNT_W'(1);
            if (rem_q == CNT_W'(1)) begin
              pend_q  <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        S_FREE: begin
          res_valid_q <= 1'b1;
          res_id_q    <= '0;
          res_idv_q   <= 1'b0;
          res_last_q  <= 1'b1;
          if (rd_q) begin
            res_status_q <= ST_OK;
            res_free_q   <= free_q + CNT_W'(1);
            free_q       <= free_q + CNT_W'(1);
          end else begin
            res_status_q <= ST_IGNORED;
            res_free_q   <= free_q;
          end
          state_q <= S_IDLE;
        end
        S_RECOUNT: begin
          if (eff_lim == '0) begin
            state_q <= S_IDLE;
          end else begin
            idx_q     <= idx_q + AW'(1);
            pend_q    <= 1'b1;
            pend_id_q <= idx_q;
            if (pend_q) begin
              free_q <= free_q + CNT_W'(!rd_q);
              if (LW'(pend_id_q) == eff_lim - LW'(1)) begin
                pend_q  <= 1'b0;
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign block_id_o   = res_id_q;
  assign id_valid_o   = res_idv_q;
  assign status_o     = res_status_q;
  assign last_o       = res_last_q;
  assign free_count_o = res_free_q;

endmodule

>>> hdl/first_fit_block_allocator_core.sv
// top level of the first-fit block allocator
//
// Requests enter on start while busy is low and wait in a two-word queue;
// results come out one per strobe on res_valid_o and must be taken in that
// cycle. After reset the bitmap memory is cleared block by block with busy
// high. Zero-length, oversized or short-of-space allocations and
// out-of-range frees finish in the cycle after they leave the queue; a valid
// free reads the bitmap, then clears the block if it was held. An allocation
// of N blocks scans the bitmap from block 0, one block per cycle through the
// single memory read port, emitting each ID as it is found. A limit write
// takes the register at once and then recounts the free blocks below the
// limit before the next request is served.
module first_fit_block_allocator_core #(
  parameter int unsigned NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode_i,
  input  logic [ffba_pkg::CNT_W-1:0]    request_count_i,
  input  logic [ffba_pkg::ID_W-1:0]     free_id_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffba_pkg::CNT_W-1:0]    cfg_data_i,
  output logic                          res_valid_o,
  output logic [ffba_pkg::ID_W-1:0]     block_id_o,
  output logic                          id_valid_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  output logic [ffba_pkg::CNT_W-1:0]    free_count_o
);
  import ffba_pkg::*;

  cmd_word_t cmd;
  back_ctl_t back_ctl;

  ffba_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .request_count_i (request_count_i),
    .free_id_i       (free_id_i),
    .back_ctl_i      (back_ctl),
    .cmd_o           (cmd)
  );

  ffba_back #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .ctl_o        (back_ctl),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .res_valid_o  (res_valid_o),
    .block_id_o   (block_id_o),
    .id_valid_o   (id_valid_o),
    .status_o     (status_o),
    .last_o       (last_o),
    .free_count_o (free_count_o)
  );

endmodule

>>> tb/tb_first_fit_block_allocator_core.sv
// testbench for the first-fit block allocator: directed and random requests with a predictor
module tb_first_fit_block_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int unsigned NB = NUM_BLOCKS_DEF;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 150;

  typedef struct {
    logic [ID_W-1:0]  block_id;
    logic             id_valid;
    status_e          status;
    logic             last;
    logic [CNT_W-1:0] free_count;
  } alloc_result_t;

  class alloc_scoreboard;
    bit [NB-1:0]      used_map;
    logic [CNT_W-1:0] limit_reg;
    alloc_result_t    expected_q[$];
    int unsigned      errors;

    function new();
      used_map  = '0;
      limit_reg = LIMIT_RESET;
      errors    = 0;
    endfunction

    function int unsigned managed();
      return (limit_reg > NB) ? NB : limit_reg;
    endfunction

    function int unsigned free_blocks();
      int unsigned n;
      n = 0;
      for (int unsigned i = 0; i < managed(); i++) begin
        if (!used_map[i]) n++;
      end
      return n;
    endfunction

    function void note_config(logic [CNT_W-1:0] value);
      limit_reg = value;
    endfunction

    function void push_result(int unsigned id, logic vld, status_e st, int unsigned fc);
      alloc_result_t r;
      r.block_id   = ID_W'(id);
      r.id_valid   = vld;
      r.status     = st;
      r.last       = 1'b1;
      r.free_count = CNT_W'(fc);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_request(op_e op, logic [CNT_W-1:0] count, logic [ID_W-1:0] fid);
      int unsigned lim;
      int unsigned fc;
      int unsigned k;
      alloc_result_t r;
      lim = managed();
      fc  = free_blocks();
      if (op == OP_ALLOC) begin
        if (count == 0) begin
          push_result(0, 1'b0, ST_OK, fc);
        end else if (count > fc || count > MAX_RESULTS) begin
          push_result(0, 1'b0, ST_NO_SPACE, fc);
        end else begin
          k = 0;
          for (int unsigned i = 0; i < lim && k < count; i++) begin
            if (!used_map[i]) begin
              used_map[i] = 1'b1;
              fc--;
              k++;
              r.block_id   = ID_W'(i);
              r.id_valid   = 1'b1;
              r.status     = ST_OK;
              r.last       = (k == count);
              r.free_count = CNT_W'(fc);
              expected_q.insert(expected_q.size(), r);
            end
          end
        end
      end else if (fid < lim && used_map[fid]) begin
        used_map[fid] = 1'b0;
        push_result(0, 1'b0, ST_OK, fc + 1);
      end else begin
        push_result(0, 1'b0, ST_IGNORED, fc);
      end
    endfunction

    function void check_result(logic [ID_W-1:0] id, logic vld, logic [1:0] st, logic lst,
                               logic [CNT_W-1:0] fc);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: block_id %0d status %0d", id, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (id !== e.block_id) begin
        $error("block_id mismatch: expected %0d, actual %0d", e.block_id, id);
        errors++;
      end
      if (vld !== e.id_valid) begin
        $error("id_valid mismatch: expected %0d, actual %0d", e.id_valid, vld);
        errors++;
      end
      if (st !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last mismatch: expected %0d, actual %0d", e.last, lst);
        errors++;
      end
      if (fc !== e.free_count) begin
        $error("free_count mismatch: expected %0d, actual %0d", e.free_count, fc);
        errors++;
      end
    endfunction

    // random block that a free would release, or -1 when none is held
    function int pick_used();
      int ids[$];
      for (int unsigned i = 0; i < managed(); i++) begin
        if (used_map[i]) ids.insert(ids.size(), i);
      end
      if (ids.size() == 0) return -1;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             opcode_i;
  logic [CNT_W-1:0] request_count_i;
  logic [ID_W-1:0]  free_id_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;
  logic             res_valid_o;
  logic [ID_W-1:0]  block_id_o;
  logic             id_valid_o;
  logic [1:0]       status_o;
  logic             last_o;
  logic [CNT_W-1:0] free_count_o;

  alloc_scoreboard sb;
  bit              gaps_on;
  int unsigned     quiet_cycles;

  first_fit_block_allocator_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .request_count_i(request_count_i),
    .free_id_i      (free_id_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .res_valid_o    (res_valid_o),
    .block_id_o     (block_id_o),
    .id_valid_o     (id_valid_o),
    .status_o       (status_o),
    .last_o         (last_o),
    .free_count_o   (free_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      sb.check_result(block_id_o, id_valid_o, status_o, last_o, free_count_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || res_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(op_e op, logic [CNT_W-1:0] count, logic [ID_W-1:0] fid);
    while (gaps_on && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    opcode_i        <= op;
    request_count_i <= count;
    free_id_i       <= fid;
    do @(posedge clk_i); while (busy);
    sb.note_request(op, count, fid);
  endtask

  // unused field of each word carries random junk
  task automatic alloc_blocks(logic [CNT_W-1:0] count);
    send_request(OP_ALLOC, count, ID_W'($urandom));
  endtask

  task automatic free_block(logic [ID_W-1:0] fid);
    send_request(OP_FREE, CNT_W'($urandom), fid);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] value);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8 + $urandom_range(0, 3)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(value);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= CNT_W'($urandom);
  endtask

  task automatic random_item();
    int unsigned r;
    int          id;
    r = $urandom_range(0, 99);
    if (sb.free_blocks() < 4 && r < 45) r = 50;
    if (r < 40) begin
      alloc_blocks(CNT_W'($urandom_range(1, 6)));
    end else if (r < 45) begin
      alloc_blocks(CNT_W'($urandom_range(7, 64)));
    end else if (r < 85) begin
      id = sb.pick_used();
      free_block((id < 0) ? ID_W'($urandom) : ID_W'(id));
    end else if (r < 92) begin
      free_block(ID_W'($urandom));
    end else if (r < 96) begin
      alloc_blocks('0);
    end else begin
      alloc_blocks(CNT_W'($urandom_range(0, 127)));
    end
  endtask

  task automatic random_phase(logic [CNT_W-1:0] limit, int unsigned count, bit quiet_stretch);
    write_limit(limit);
    for (int unsigned i = 0; i < count; i++) begin
      gaps_on = !(quiet_stretch && i >= count / 4 && i < count / 2);
      random_item();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    sb              = new();
    gaps_on         = 1'b1;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    opcode_i        = OP_ALLOC;
    request_count_i = '0;
    free_id_i       = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_limit(CNT_W'(64));
    alloc_blocks('0);
    free_block(ID_W'(5));
    alloc_blocks(CNT_W'(1));
    alloc_blocks(CNT_W'(3));
    free_block(ID_W'(2));
    alloc_blocks(CNT_W'(2));
    alloc_blocks(CNT_W'(127));
    alloc_blocks(CNT_W'(65));
    alloc_blocks(CNT_W'(64));
    alloc_blocks(CNT_W'(59));
    alloc_blocks(CNT_W'(1));
    free_block(ID_W'(63));
    free_block(ID_W'(0));
    alloc_blocks(CNT_W'(2));
    free_block(ID_W'(63));

    // blocks above a lowered limit stay held and cannot be released
    write_limit(CNT_W'(17));
    free_block(ID_W'(40));
    free_block(ID_W'(16));
    alloc_blocks(CNT_W'(1));
    alloc_blocks(CNT_W'(1));

    write_limit('0);
    alloc_blocks('0);
    alloc_blocks(CNT_W'(1));
    free_block(ID_W'(3));

    write_limit(CNT_W'(127));
    free_block(ID_W'(40));
    alloc_blocks(CNT_W'(2));

    random_phase(CNT_W'(64), 45, 1'b1);
    random_phase(CNT_W'(1), 15, 1'b0);
    random_phase(CNT_W'(17), 40, 1'b0);
    random_phase(CNT_W'(127), 40, 1'b1);
    random_phase(CNT_W'(40), 30, 1'b0);
    random_phase('0, 8, 1'b0);
    random_phase(CNT_W'(64), 20, 1'b0);

    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> first_fit_block_allocator_core.f
hdl/ffba_pkg.sv
hdl/ffba_front.sv
hdl/ffba_back.sv
hdl/first_fit_block_allocator_core.sv
tb/tb_first_fit_block_allocator_core.sv
